### rtl/iqp_pkg.sv
// ----------------------------------------------------------------------------
// iqp_pkg
// Shared types and codes of the three-level interrupt priority queue.
// ----------------------------------------------------------------------------
package iqp_pkg;

	localparam int LineW     = 4;
	localparam int IrqLines  = 16;
	localparam int MapW      = 64;
	localparam int CfgIdxW   = 3;

	typedef enum logic {
		CMD_ARRIVE = 1'b0,
		CMD_SERVE  = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_INACTIVE  = 3'd1,
		ST_UNHANDLED = 3'd2,
		ST_FULL      = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		LVL_HIGH = 2'd0,
		LVL_MED  = 2'd1,
		LVL_LOW  = 2'd2
	} level_t;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_ACTIVE   = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_HIGH     = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_MED_A    = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_MED_B    = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_LOW_A    = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_LOW_B    = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_SENS_MAP = 3'd6;

	typedef struct packed {
		logic             active;
		logic [LineW-1:0] high_line;
		logic [LineW-1:0] med_line_a;
		logic [LineW-1:0] med_line_b;
		logic [LineW-1:0] low_line_a;
		logic [LineW-1:0] low_line_b;
		logic [MapW-1:0]  sensor_map;
	} cfg_t;

	localparam cfg_t CfgReset = '{
		active:     1'b0,
		high_line:  4'd0,
		med_line_a: 4'd1,
		med_line_b: 4'd2,
		low_line_a: 4'd3,
		low_line_b: 4'd4,
		sensor_map: '0
	};

	// memory port command
	typedef struct packed {
		logic wr;
		logic rd;
	} mem_cmd_t;

	// outcome of one item as decided by the queue control
	typedef struct packed {
		status_t status;
		level_t  level;
		logic    pop;
	} res_t;

endpackage

### rtl/three_level_irq_priority_queue.sv
// ----------------------------------------------------------------------------
// three_level_irq_priority_queue
// Sorts interrupt arrivals into high, medium and low queues and serves them
// in strict priority, mapping each served line to a sensor id.
// ----------------------------------------------------------------------------
// Use:
//   Input channel (in_valid/in_ready): cmd 0 queues irq_line, cmd 1 asks for
//   one queued interrupt. Every item gives exactly one result on the output
//   channel (out_valid/out_ready): served_valid, served_line, sensor_tag,
//   served_level and status.
//   Configuration: cfg_we with cfg_idx/cfg_data writes one register; write
//   only while no item is in flight.
//   Path: an accepted item's memory access and outcome are registered in
//   stage 1, then the result moves on into the output register.
//   Throughput: one item per cycle unless the output stalls; each item makes
//   at most one access to the single-port queue memory; pointers and counts update at acceptance.
//   Reset: pointers, counts and valid flags clear and the configuration takes
//   its reset values; the queue memory is not cleared and needs no clearing pass.
//   Stall: when out_ready is low the result holds in the output register, one
//   more item completes its memory access into the stage behind it, and then
//   in_ready drops until the output moves on.
// ----------------------------------------------------------------------------
module three_level_irq_priority_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [iqp_pkg::CfgIdxW-1:0]   cfg_idx,
	input  logic [iqp_pkg::MapW-1:0]      cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          cmd,
	input  logic [iqp_pkg::LineW-1:0]     irq_line,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          served_valid,
	output logic [iqp_pkg::LineW-1:0]     served_line,
	output logic [iqp_pkg::LineW-1:0]     sensor_tag,
	output logic [1:0]                    served_level,
	output logic [2:0]                    status
);
	import iqp_pkg::*;

	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int ADDR_W = PTR_W + 2;

	cfg_t              cfg_q;
	mem_cmd_t          mem_cmd;
	logic [ADDR_W-1:0] mem_addr;
	logic [LineW-1:0]  mem_wdata;
	logic [LineW-1:0]  mem_rdata;
	res_t              res;
	logic              accept;

	// stage 1: memory access in flight
	logic              valid_s1;
	res_t              res_s1;
	logic              advance_s1;

	// output register
	logic              out_valid_q;
	logic              served_valid_q;
	logic [LineW-1:0]  line_q;
	logic [LineW-1:0]  sid_q;
	level_t            level_q;
	status_t           status_q;

	// configuration registers, masked to their widths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CfgReset;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_ACTIVE:   cfg_q.active     <= cfg_data[0];
				CFG_HIGH:     cfg_q.high_line  <= cfg_data[LineW-1:0];
				CFG_MED_A:    cfg_q.med_line_a <= cfg_data[LineW-1:0];
				CFG_MED_B:    cfg_q.med_line_b <= cfg_data[LineW-1:0];
				CFG_LOW_A:    cfg_q.low_line_a <= cfg_data[LineW-1:0];
				CFG_LOW_B:    cfg_q.low_line_b <= cfg_data[LineW-1:0];
				CFG_SENS_MAP: cfg_q.sensor_map <= cfg_data;
				default:      cfg_q            <= cfg_q;
			endcase
		end
	end

	// advance stage 1 when the output register is free or being emptied
	assign advance_s1 = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;
	assign accept     = in_valid && in_ready;

	iqp_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.PTR_W       (PTR_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cmd       (cmd_t'(cmd)),
		.irq_line  (irq_line),
		.cfg       (cfg_q),
		.mem_cmd   (mem_cmd),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.res       (res)
	);

	iqp_mem #(
		.ADDR_W (ADDR_W),
		.DATA_W (LineW)
	) u_mem (
		.clk   (clk),
		.cmd   (mem_cmd),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// hold the outcome beside the read that is under way
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// fields other than status read as zero unless an entry was served
	always_ff @(posedge clk) begin
		if (advance_s1) begin
			served_valid_q <= res_s1.pop;
			status_q       <= res_s1.status;
			line_q         <= res_s1.pop ? mem_rdata : '0;
			sid_q          <= res_s1.pop ? cfg_q.sensor_map[{mem_rdata, 2'b00} +: LineW] : '0;
			level_q        <= res_s1.pop ? res_s1.level : LVL_HIGH;
		end
	end

	assign out_valid    = out_valid_q;
	assign served_valid = served_valid_q;
	assign served_line  = line_q;
	assign sensor_tag   = sid_q;
	assign served_level = level_q;
	assign status       = status_q;

	a_served_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && served_valid_q |-> status_q == ST_OK)
		else $error("served item without ok status");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !served_valid_q |-> line_q == '0 && sid_q == '0 && level_q == LVL_HIGH)
		else $error("non-served result carries served fields");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance_s1 |=> valid_s1 && $stable(res_s1))
		else $error("stalled stage lost its item");

endmodule

### rtl/iqp_mem.sv
// ----------------------------------------------------------------------------
// iqp_mem
// Single-port queue storage with a registered read, one access per cycle.
// ----------------------------------------------------------------------------
module iqp_mem #(
	parameter int ADDR_W = 6,
	parameter int DATA_W = 4
) (
	input  logic              clk,
	input  iqp_pkg::mem_cmd_t cmd,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);
	import iqp_pkg::*;

	logic [DATA_W-1:0] mem [2**ADDR_W];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/iqp_ctrl.sv
// ----------------------------------------------------------------------------
// iqp_ctrl
// Classifies arrivals, picks the queue to serve and keeps head, tail and
// occupancy of the three queues; issues at most one memory access per item.
// ----------------------------------------------------------------------------
module iqp_ctrl #(
	parameter int QUEUE_DEPTH = 16,
	parameter int PTR_W       = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  iqp_pkg::cmd_t              cmd,
	input  logic [iqp_pkg::LineW-1:0]  irq_line,
	input  iqp_pkg::cfg_t              cfg,
	output iqp_pkg::mem_cmd_t          mem_cmd,
	output logic [PTR_W+1:0]           mem_addr,
	output logic [iqp_pkg::LineW-1:0]  mem_wdata,
	output iqp_pkg::res_t              res
);
	import iqp_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LastPtr = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FullCnt = CNT_W'(QUEUE_DEPTH);

	logic [PTR_W-1:0] head_q  [3];
	logic [PTR_W-1:0] tail_q  [3];
	logic [CNT_W-1:0] count_q [3];

	logic   arr_match;
	level_t arr_lvl;
	logic   srv_any;
	level_t srv_lvl;
	level_t sel_lvl;
	logic   in_range;

	assign in_range = (32'(irq_line) < IrqLines);

	// arrival classification: high first, then medium, then low
	always_comb begin
		arr_match = 1'b1;
		arr_lvl   = LVL_HIGH;
		priority if (!in_range) begin
			arr_match = 1'b0;
		end else if (irq_line == cfg.high_line) begin
			arr_lvl = LVL_HIGH;
		end else if (irq_line == cfg.med_line_a || irq_line == cfg.med_line_b) begin
			arr_lvl = LVL_MED;
		end else if (irq_line == cfg.low_line_a || irq_line == cfg.low_line_b) begin
			arr_lvl = LVL_LOW;
		end else begin
			arr_match = 1'b0;
		end
	end

	// service picks the highest non-empty queue
	always_comb begin
		srv_any = 1'b1;
		srv_lvl = LVL_HIGH;
		priority if (count_q[LVL_HIGH] != '0) begin
			srv_lvl = LVL_HIGH;
		end else if (count_q[LVL_MED] != '0) begin
			srv_lvl = LVL_MED;
		end else if (count_q[LVL_LOW] != '0) begin
			srv_lvl = LVL_LOW;
		end else begin
			srv_any = 1'b0;
		end
	end

	always_comb begin
		mem_cmd    = '0;
		res.status = ST_OK;
		res.level  = LVL_HIGH;
		res.pop    = 1'b0;
		sel_lvl    = (cmd == CMD_ARRIVE) ? arr_lvl : srv_lvl;
		unique case (cmd)
			CMD_ARRIVE: begin
				priority if (!cfg.active) begin
					res.status = ST_INACTIVE;
				end else if (!arr_match) begin
					res.status = ST_UNHANDLED;
				end else if (count_q[arr_lvl] == FullCnt) begin
					res.status = ST_FULL;
				end else begin
					mem_cmd.wr = accept;
				end
			end
			CMD_SERVE: begin
				if (!srv_any) begin
					res.status = ST_EMPTY;
				end else begin
					res.pop    = 1'b1;
					res.level  = srv_lvl;
					mem_cmd.rd = accept;
				end
			end
			default: res.status = ST_OK;
		endcase
	end

	assign mem_addr  = {sel_lvl, (cmd == CMD_ARRIVE) ? tail_q[sel_lvl] : head_q[sel_lvl]};
	assign mem_wdata = irq_line;

	// advance the pointer and occupancy of the queue touched by this item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (mem_cmd.wr) begin
			tail_q[sel_lvl]  <= (tail_q[sel_lvl] == LastPtr) ? '0
				: tail_q[sel_lvl] + PTR_W'(1);
			count_q[sel_lvl] <= count_q[sel_lvl] + CNT_W'(1);
		end else if (mem_cmd.rd) begin
			head_q[sel_lvl]  <= (head_q[sel_lvl] == LastPtr) ? '0
				: head_q[sel_lvl] + PTR_W'(1);
			count_q[sel_lvl] <= count_q[sel_lvl] - CNT_W'(1);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q[0] <= FullCnt && count_q[1] <= FullCnt && count_q[2] <= FullCnt)
		else $error("queue occupancy above depth");

	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_cmd.wr && mem_cmd.rd))
		else $error("write and read issued together");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		mem_cmd.wr |=> count_q[$past(sel_lvl)] == $past(count_q[sel_lvl]) + CNT_W'(1))
		else $error("push did not raise occupancy");

endmodule
